// ===== hw/rtl/triangle_grid_linear_prolongation_assert.svh =====
// ----------------------------------------------------------------------------
// Triangle grid prolongation assertion macros
// Shorthand for the concurrent checks placed at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_GRID_LINEAR_PROLONGATION_ASSERT_SVH
`define TRIANGLE_GRID_LINEAR_PROLONGATION_ASSERT_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define TGLP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The condition must never be seen at a clock edge out of reset.
`define TGLP_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error(msg);

`endif

// ===== hw/rtl/tglp_pkg.sv =====
// ----------------------------------------------------------------------------
// Triangle grid prolongation package
// Shared widths, defaults and the queue status type.
// ----------------------------------------------------------------------------
`default_nettype none

package tglp_pkg;

    localparam int unsigned MAX_COARSE_LEVEL_DEF = 10;
    localparam int unsigned VALUE_WIDTH_DEF      = 32;

    // Level register and fine coordinate widths are fixed by the port list.
    localparam int unsigned LEVEL_W     = 4;
    localparam int unsigned FINE_W      = 12;
    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 4'd2;

    localparam int unsigned QUEUE_DEPTH = 2;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

// ===== hw/rtl/triangle_grid_linear_prolongation.sv =====
// ----------------------------------------------------------------------------
// Triangle grid linear prolongation
// Streams the coarse samples of one triangular patch and produces the fine
// copies and edge midpoints of linear interpolation.
// ----------------------------------------------------------------------------
// Samples enter in row order and are accepted one per cycle while o_stall is
// low; a sample on the first row or the first column of the patch produces
// nothing. Every other sample produces three results (four for strictly
// interior points), which leave through a single output register at one per
// cycle while i_stall is low. A two-entry queue separates the front end from
// the back end, and each sample's results pass from the stage-one registers
// through the queue into the output register. The previous row lives in a
// RAM of 2^MAX_COARSE_LEVEL+1 words that is read and written once per sample.
// A write of the level register restarts the patch; write it only while idle.
`default_nettype none

module triangle_grid_linear_prolongation #(
    parameter int unsigned MAX_COARSE_LEVEL = tglp_pkg::MAX_COARSE_LEVEL_DEF,
    parameter int unsigned VALUE_WIDTH      = tglp_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wen,
    input  wire logic [tglp_pkg::LEVEL_W-1:0]  i_cfg_wdata,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic signed [VALUE_WIDTH-1:0] i_coarse_value,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic      [tglp_pkg::FINE_W-1:0]   o_fine_row,
    output logic      [tglp_pkg::FINE_W-1:0]   o_fine_col,
    output logic signed [VALUE_WIDTH-1:0]      o_fine_value,
    output logic                               o_last_of_run
);

    import tglp_pkg::*;

    localparam int unsigned CW = MAX_COARSE_LEVEL + 1;
    localparam int unsigned EW = 3 * VALUE_WIDTH + 2 * CW + 1;

    logic          push;
    logic          pop;
    logic [EW-1:0] front_item;
    logic [EW-1:0] head_item;
    t_q_stat       q_stat;

    tglp_front #(
        .MAX_LVL (MAX_COARSE_LEVEL),
        .VW      (VALUE_WIDTH),
        .EW      (EW)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wen      (i_cfg_wen),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_coarse_value (i_coarse_value),
        .o_push         (push),
        .o_item         (front_item),
        .i_q_stat       (q_stat)
    );

    tglp_queue #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_item),
        .i_pop   (pop),
        .o_data  (head_item),
        .o_stat  (q_stat)
    );

    tglp_back #(
        .MAX_LVL (MAX_COARSE_LEVEL),
        .VW      (VALUE_WIDTH),
        .EW      (EW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (head_item),
        .i_q_stat      (q_stat),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_fine_row    (o_fine_row),
        .o_fine_col    (o_fine_col),
        .o_fine_value  (o_fine_value),
        .o_last_of_run (o_last_of_run)
    );

`include "triangle_grid_linear_prolongation_assert.svh"

    `TGLP_ASSERT_NEVER(a_push_full, i_clk, i_rst_n, push && q_stat.full, "push into full queue")
    `TGLP_ASSERT_NEVER(a_pop_empty, i_clk, i_rst_n, pop && q_stat.empty, "pop from empty queue")
    `TGLP_ASSERT_IMP(a_stall_full, i_clk, i_rst_n, o_stall, !q_stat.empty, "stall with idle queue")
    `TGLP_ASSERT_IMP(a_last_is_col, i_clk, i_rst_n, o_valid && o_last_of_run, o_fine_col[0] && !o_fine_row[0], "run does not end on column midpoint")

endmodule

`default_nettype wire

// ===== hw/rtl/tglp_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write and one registered read per cycle; a read of the address being
// written returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module tglp_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1025
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/tglp_queue.sv =====
// ----------------------------------------------------------------------------
// Triangle grid prolongation work queue
// Short FIFO of classified samples between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tglp_queue #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output tglp_pkg::t_q_stat     o_stat
);

    import tglp_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr;
    logic [PW-1:0]    r_rptr;
    logic [CNTW-1:0]  r_count;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        if (p == PW'(DEPTH - 1)) begin
            return '0;
        end
        return p + PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= ptr_inc(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= ptr_inc(r_rptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNTW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNTW'(1);
            end
        end
    end

    assign o_data       = r_mem[r_rptr];
    assign o_stat.full  = (r_count == CNTW'(DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

`default_nettype wire

// ===== hw/rtl/tglp_front.sv =====
// ----------------------------------------------------------------------------
// Triangle grid prolongation front end
// Accepts coarse samples, tracks the patch position, keeps the previous row
// and sample, and queues the samples that produce fine results.
// ----------------------------------------------------------------------------
`default_nettype none

module tglp_front #(
    parameter int unsigned MAX_LVL = 10,
    parameter int unsigned VW      = 32,
    parameter int unsigned EW      = 3 * 32 + 2 * 11 + 1
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wen,
    input  wire logic [tglp_pkg::LEVEL_W-1:0]  i_cfg_wdata,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic signed [VW-1:0]          i_coarse_value,
    output logic                               o_push,
    output logic      [EW-1:0]                 o_item,
    input  wire tglp_pkg::t_q_stat             i_q_stat
);

    import tglp_pkg::*;

    localparam int unsigned CW    = MAX_LVL + 1;
    localparam int unsigned DEPTH = (1 << MAX_LVL) + 1;

    logic [LEVEL_W-1:0] r_level;
    logic [CW-1:0]      r_row;
    logic [CW-1:0]      r_col;
    logic [VW-1:0]      r_prev;

    logic               r_s1_vld;
    logic               r_s1_emit;
    logic               r_s1_int;
    logic [CW-1:0]      r_s1_row;
    logic [CW-1:0]      r_s1_col;
    logic [VW-1:0]      r_s1_cur;
    logic [VW-1:0]      r_s1_left;

    logic [LEVEL_W-1:0] lvl;
    logic [CW-1:0]      pts;
    logic [CW:0]        pts_ext;
    logic [CW:0]        diag_sum;
    logic               emit;
    logic               interior;
    logic               row_end;
    logic [CW-1:0]      n_row;
    logic [CW-1:0]      n_col;
    logic               accept;
    logic               s1_free;
    logic [VW-1:0]      ram_up;

    // Levels above the supported maximum behave as the maximum.
    assign lvl      = (r_level > LEVEL_W'(MAX_LVL)) ? LEVEL_W'(MAX_LVL) : r_level;
    assign pts      = (CW'(1) << lvl) + CW'(1);
    assign pts_ext  = {1'b0, pts};
    assign diag_sum = {1'b0, r_row} + {1'b0, r_col};

    assign emit     = (r_row != '0) && (r_col != '0) && (diag_sum < pts_ext);
    assign interior = (diag_sum + (CW + 1)'(2)) <= pts_ext;
    assign row_end  = (r_row >= pts) || ((diag_sum + (CW + 1)'(1)) >= pts_ext);

    always_comb begin
        n_row = r_row;
        n_col = r_col + CW'(1);
        if (row_end) begin
            n_col = '0;
            n_row = ((r_row + CW'(1)) >= pts) ? '0 : r_row + CW'(1);
        end
    end

    // Samples that produce nothing leave stage one without using the queue.
    assign s1_free = !r_s1_vld || !r_s1_emit || !i_q_stat.full;
    assign o_stall = !s1_free;
    assign accept  = i_valid && s1_free;
    assign o_push  = r_s1_vld && r_s1_emit && !i_q_stat.full;

    tglp_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_col),
        .i_wdata (i_coarse_value),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (ram_up)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level  <= LEVEL_RESET;
            r_row    <= '0;
            r_col    <= '0;
            r_prev   <= '0;
            r_s1_vld <= 1'b0;
        end else if (i_cfg_wen) begin
            r_level <= i_cfg_wdata;
            r_row   <= '0;
            r_col   <= '0;
            r_prev  <= '0;
        end else if (accept) begin
            r_row    <= n_row;
            r_col    <= n_col;
            r_prev   <= i_coarse_value;
            r_s1_vld <= 1'b1;
        end else if (s1_free) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_emit <= emit;
            r_s1_int  <= interior;
            r_s1_row  <= r_row;
            r_s1_col  <= r_col;
            r_s1_cur  <= i_coarse_value;
            r_s1_left <= r_prev;
        end
    end

    assign o_item = {r_s1_int, r_s1_row, r_s1_col, ram_up, r_s1_left, r_s1_cur};

endmodule

`default_nettype wire

// ===== hw/rtl/tglp_back.sv =====
// ----------------------------------------------------------------------------
// Triangle grid prolongation back end
// Expands each queued sample into its midpoint results and, for interior
// points, its copy, one result per cycle unless i_stall holds the output.
// ----------------------------------------------------------------------------
`default_nettype none

module tglp_back #(
    parameter int unsigned MAX_LVL = 10,
    parameter int unsigned VW      = 32,
    parameter int unsigned EW      = 3 * 32 + 2 * 11 + 1
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [EW-1:0]                i_item,
    input  wire tglp_pkg::t_q_stat            i_q_stat,
    output logic                              o_pop,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic      [tglp_pkg::FINE_W-1:0]  o_fine_row,
    output logic      [tglp_pkg::FINE_W-1:0]  o_fine_col,
    output logic signed [VW-1:0]              o_fine_value,
    output logic                              o_last_of_run
);

    import tglp_pkg::*;

    localparam int unsigned CW = MAX_LVL + 1;
    localparam int unsigned XW = (CW + 1 > FINE_W) ? CW + 1 : FINE_W;

    localparam logic [1:0] PH_COPY = 2'd0;
    localparam logic [1:0] PH_DIAG = 2'd1;
    localparam logic [1:0] PH_ROW  = 2'd2;
    localparam logic [1:0] PH_COL  = 2'd3;

    logic [1:0]        r_idx;
    logic              r_out_vld;
    logic [FINE_W-1:0] r_fine_row;
    logic [FINE_W-1:0] r_fine_col;
    logic [VW-1:0]     r_fine_value;
    logic              r_last;

    logic [VW-1:0]     cur;
    logic [VW-1:0]     left;
    logic [VW-1:0]     up;
    logic [CW-1:0]     col;
    logic [CW-1:0]     row;
    logic              interior;
    logic [1:0]        phase;
    logic              last;
    logic              out_free;
    logic              go;
    logic [XW-1:0]     row2;
    logic [XW-1:0]     col2;
    logic [XW-1:0]     sel_row;
    logic [XW-1:0]     sel_col;
    logic [VW-1:0]     op_a;
    logic [VW-1:0]     op_b;
    logic              use_avg;
    logic [VW:0]       sum;
    logic [VW-1:0]     n_value;

    assign cur      = i_item[VW-1:0];
    assign left     = i_item[2*VW-1:VW];
    assign up       = i_item[3*VW-1:2*VW];
    assign col      = i_item[3*VW+CW-1:3*VW];
    assign row      = i_item[3*VW+2*CW-1:3*VW+CW];
    assign interior = i_item[EW-1];

    // Edge points skip the copy, so their run starts at the diagonal midpoint.
    assign phase    = r_idx + {1'b0, !interior};
    assign last     = (phase == PH_COL);
    assign out_free = !r_out_vld || !i_stall;
    assign go       = !i_q_stat.empty && out_free;
    assign o_pop    = go && last;

    assign row2 = XW'({row, 1'b0});
    assign col2 = XW'({col, 1'b0});

    always_comb begin
        sel_row = row2;
        sel_col = col2;
        op_a    = cur;
        op_b    = cur;
        use_avg = 1'b1;
        case (phase)
            PH_COPY: begin
                use_avg = 1'b0;
            end
            PH_DIAG: begin
                sel_row = row2 - XW'(1);
                sel_col = col2 - XW'(1);
                op_a    = up;
                op_b    = left;
            end
            PH_ROW: begin
                sel_row = row2 - XW'(1);
                op_b    = up;
            end
            PH_COL: begin
                sel_col = col2 - XW'(1);
                op_b    = left;
            end
            default: begin
                use_avg = 1'b0;
            end
        endcase
    end

    // The sum keeps one extra bit, so dropping its low bit is an exact floor.
    assign sum     = {op_a[VW-1], op_a} + {op_b[VW-1], op_b};
    assign n_value = use_avg ? sum[VW:1] : cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_vld <= go;
            end
            if (go) begin
                r_idx <= last ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_fine_row   <= sel_row[FINE_W-1:0];
            r_fine_col   <= sel_col[FINE_W-1:0];
            r_fine_value <= n_value;
            r_last       <= last;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_fine_row    = r_fine_row;
    assign o_fine_col    = r_fine_col;
    assign o_fine_value  = r_fine_value;
    assign o_last_of_run = r_last;

endmodule

`default_nettype wire

// ===== tb/triangle_grid_linear_prolongation_tb.sv =====
// ----------------------------------------------------------------------------
// Triangle grid linear prolongation testbench
// Streams coarse patches at several refinement levels, with random gaps and
// back-pressure, and checks every fine result against a scoreboard that
// tracks the patch position, the previous row and the previous sample.
// ----------------------------------------------------------------------------
module triangle_grid_linear_prolongation_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tglp_pkg::*;

    localparam int unsigned VW            = VALUE_WIDTH_DEF;
    localparam int unsigned MAX_LVL       = MAX_COARSE_LEVEL_DEF;
    localparam int unsigned ROW_WORDS     = (1 << MAX_LVL) + 1;
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned IDLE_PERCENT  = 22;
    localparam int unsigned RANDOM_ITEMS  = 90;

    typedef struct packed {
        logic [FINE_W-1:0] row;
        logic [FINE_W-1:0] col;
        logic [VW-1:0]     value;
        logic              is_last;
    } t_fine_point;

    class prolongation_board;
        logic [LEVEL_W-1:0] coarse_level;
        logic [VW-1:0]      row_store [ROW_WORDS];
        logic [VW-1:0]      left_sample;
        int unsigned        row_pos;
        int unsigned        col_pos;
        t_fine_point        fine_q [$];
        int unsigned        fail_count;

        function new();
            coarse_level = LEVEL_RESET;
            left_sample  = '0;
            row_pos      = 0;
            col_pos      = 0;
            fail_count   = 0;
        endfunction

        // A level write starts a fresh patch; the row store keeps its contents.
        function void restart(logic [LEVEL_W-1:0] lvl);
            coarse_level = lvl;
            left_sample  = '0;
            row_pos      = 0;
            col_pos      = 0;
        endfunction

        function int unsigned pending();
            return fine_q.size();
        endfunction

        // Floor of the mean, taken on a sum one bit wider so nothing overflows.
        function logic [VW-1:0] midpoint(logic [VW-1:0] a, logic [VW-1:0] b);
            logic [VW:0] total;
            total = {a[VW-1], a} + {b[VW-1], b};
            return total[VW:1];
        endfunction

        function void push_point(int unsigned r, int unsigned c, logic [VW-1:0] v,
                                 logic is_last);
            t_fine_point p;
            p.row     = r[FINE_W-1:0];
            p.col     = c[FINE_W-1:0];
            p.value   = v;
            p.is_last = is_last;
            fine_q.push_back(p);
        endfunction

        function void note_sample(logic [VW-1:0] sample);
            int unsigned   eff_level;
            int unsigned   span;
            int unsigned   r;
            int unsigned   c;
            logic [VW-1:0] above;
            eff_level = (coarse_level > MAX_LVL) ? MAX_LVL : coarse_level;
            span      = (1 << eff_level) + 1;
            r         = row_pos;
            c         = col_pos;
            above     = row_store[c];
            if (r >= 1 && c >= 1 && r + c <= span - 1) begin
                if (r + c <= span - 2) begin
                    push_point(2 * r, 2 * c, sample, 1'b0);
                end
                push_point(2 * r - 1, 2 * c - 1, midpoint(above, left_sample), 1'b0);
                push_point(2 * r - 1, 2 * c, midpoint(sample, above), 1'b0);
                push_point(2 * r, 2 * c - 1, midpoint(sample, left_sample), 1'b1);
            end
            row_store[c] = sample;
            left_sample  = sample;
            col_pos      = c + 1;
            if (col_pos >= span - r) begin
                col_pos = 0;
                row_pos = (r + 1 >= span) ? 0 : r + 1;
            end
        endfunction

        task report(string what);
            fail_count++;
            if (fail_count <= 40) begin
                $display("ERROR at %0t: %s", $realtime, what);
            end
        endtask

        task check_result(t_fine_point got);
            t_fine_point want;
            if (fine_q.size() == 0) begin
                report($sformatf("unexpected result at (%0d,%0d) value %0d",
                                 got.row, got.col, $signed(got.value)));
                return;
            end
            want = fine_q.pop_front();
            if (got.row !== want.row) begin
                report($sformatf("fine_row: got %0d, expected %0d", got.row, want.row));
            end
            if (got.col !== want.col) begin
                report($sformatf("fine_col: got %0d, expected %0d", got.col, want.col));
            end
            if (got.value !== want.value) begin
                report($sformatf("fine_value at (%0d,%0d): got %0d, expected %0d",
                                 want.row, want.col, $signed(got.value),
                                 $signed(want.value)));
            end
            if (got.is_last !== want.is_last) begin
                report($sformatf("last_of_run at (%0d,%0d): got %b, expected %b",
                                 want.row, want.col, got.is_last, want.is_last));
            end
        endtask
    endclass

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_cfg_wen      = 1'b0;
    logic [LEVEL_W-1:0]   i_cfg_wdata    = '0;
    logic                 i_valid        = 1'b0;
    logic                 o_stall;
    logic signed [VW-1:0] i_coarse_value = '0;
    logic                 o_valid;
    logic                 i_stall        = 1'b0;
    logic [FINE_W-1:0]    o_fine_row;
    logic [FINE_W-1:0]    o_fine_col;
    logic signed [VW-1:0] o_fine_value;
    logic                 o_last_of_run;

    prolongation_board board;
    bit                calm        = 1'b0;
    int unsigned       quiet_count = 0;

    triangle_grid_linear_prolongation uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_coarse_value(i_coarse_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_fine_row    (o_fine_row),
        .o_fine_col    (o_fine_col),
        .o_fine_value  (o_fine_value),
        .o_last_of_run (o_last_of_run)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
    end

    // Transfers are observed at the edge, before any register updates land.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                board.note_sample(i_coarse_value);
            end
            if (o_valid && !i_stall) begin
                board.check_result('{o_fine_row, o_fine_col, o_fine_value, o_last_of_run});
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_count <= 0;
            end else if (quiet_count >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end else begin
                quiet_count <= quiet_count + 1;
            end
        end
    end

    function automatic logic [VW-1:0] random_value();
        case ($urandom_range(0, 9))
            0:       return {1'b0, {(VW-1){1'b1}}};
            1:       return {1'b1, {(VW-1){1'b0}}};
            2:       return '0;
            3:       return '1;
            4:       return VW'($signed($urandom_range(0, 8)) - 4);
            default: return VW'($urandom);
        endcase
    endfunction

    // Holds valid until the transfer; the caller lowers it after the last one.
    task automatic send_sample(input logic [VW-1:0] sample);
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_coarse_value <= sample;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_random(input int unsigned count);
        repeat (count) begin
            send_sample(random_value());
        end
        i_valid <= 1'b0;
    endtask

    // One level-2 patch chosen to hit the sign extremes, odd sums and
    // rounding towards minus infinity, followed by the start of the next.
    task automatic send_directed();
        logic [VW-1:0] patch [20];
        patch = '{
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
            32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
            32'h0001_0000, 32'hFFFF_0001,
            32'h5555_5555,
            32'hAAAA_AAAA, 32'h0000_0003, 32'hFFFF_FFFD, 32'h7FFF_FFFE, 32'h8000_0001
        };
        foreach (patch[k]) begin
            send_sample(patch[k]);
        end
        i_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (board.pending() != 0) begin
            @(posedge i_clk);
        end
        // Samples that produce nothing may still be inside the pipeline.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_level(input logic [LEVEL_W-1:0] lvl);
        wait_drained();
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= lvl;
        @(posedge i_clk);
        board.restart(lvl);
        i_cfg_wen <= 1'b0;
    endtask

    initial begin
        int unsigned sent;
        int unsigned phase;
        int unsigned count;
        board = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_directed();
        write_level(4'd0);
        send_random(9);
        write_level(4'd1);
        send_random(14);

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            count = $urandom_range(20, 45);
            calm  = (phase == 1);
            write_level(LEVEL_W'($urandom_range(1, 4)));
            send_random(count);
            sent += count;
            phase++;
        end
        calm = 1'b0;

        // A deeper level needs a full first row before anything is produced.
        write_level(LEVEL_W'(5));
        send_random(45);
        write_level(4'd15);
        send_random(12);
        write_level(LEVEL_RESET);
        send_random(10);

        wait_drained();
        if (board.fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
